// File: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Command codes, controller states and the fixed widths of the word fields.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Fixed widths of the word fields.
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned WRAP_W = 8;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] LF_CHAR    = 8'h0A;
  localparam logic [CHAR_W-1:0] CR_CHAR    = 8'h0D;
  localparam logic [WRAP_W-1:0] WRAP_MAX   = 8'hFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT        = 3'd0,
    CMD_BACKSPACE  = 3'd1,
    CMD_CLEAR      = 3'd2,
    CMD_RESET_WRAP = 3'd3,
    CMD_READ       = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_RDATA,
    ST_DONE
  } state_e;

endpackage : tcw_pkg

`default_nettype wire

// File: rtl/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if: command and response channels of the text console writer
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_cmd_if
  import tcw_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CHAR_W-1:0] char_code;
  logic [ROW_W-1:0]  read_row;
  logic [COL_W-1:0]  read_col;

  modport source (output valid, output cmd, output char_code, output read_row,
                  output read_col, input ready);
  modport sink   (input valid, input cmd, input char_code, input read_row,
                  input read_col, output ready);
endinterface : tcw_cmd_if

interface tcw_rsp_if
  import tcw_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [WRAP_W-1:0] wrap_count;
  logic [CHAR_W-1:0] cell_char;

  modport source (output valid, output cursor_col, output cursor_row,
                  output wrap_count, output cell_char, input ready);
  modport sink   (input valid, input cursor_col, input cursor_row,
                  input wrap_count, input cell_char, output ready);
endinterface : tcw_rsp_if

`default_nettype wire

// File: rtl/text_console_writer.sv
// Put, newline, backspace, wrap reset, unused codes and off-screen reads finish in
// ST_EXEC; a cell read goes on to ST_RDATA; a scroll or a clear goes on to ST_SWEEP.
// The response word is registered when the command finishes.
// cmd_i.ready is high only when idle, so a new command is taken only after the last
// one finishes, and a word held by rsp_o.ready keeps the block from going idle.
// Reset: asynchronous, active low; then a pass writes spaces to all ROWS*COLUMNS cells.
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console
// Keeps a screen of character codes in a RAM, a cursor and a saturating
// count of automatic line wraps, and answers each command with one word.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tcw_cmd_if.sink    cmd_i,
  tcw_rsp_if.source  rsp_o
);

  // The screen is a ring of rows: logical row r lives in physical row
  // (r + top) mod ROWS. A scroll only moves top and blanks one physical row,
  // so it costs COLUMNS writes instead of a copy of the whole screen.
  localparam int unsigned DEPTH = ROWS * COLUMNS;
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [RW:0]   ROWS_X    = (RW + 1)'(ROWS);
  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);

  // Controller state.
  state_e state_q, state_d;

  // Architectural state of the console.
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [RW-1:0]     top_q, top_d;
  logic [WRAP_W-1:0] wraps_q, wraps_d;

  // Command word held while it executes.
  logic [CMD_W-1:0]  cmd_q;
  logic [CHAR_W-1:0] char_q;
  logic [ROW_W-1:0]  rrow_q;
  logic [COL_W-1:0]  rcol_q;

  // Sweep engine used for the reset pass, clears and scrolls.
  logic [AW-1:0] sweep_addr_q, sweep_addr_d;
  logic [AW-1:0] sweep_end_q, sweep_end_d;

  // Cell value of the current command and the response register.
  logic [CHAR_W-1:0] cell_q, cell_d;
  logic              out_valid_q, out_valid_d;
  logic [CW-1:0]     out_col_q;
  logic [RW-1:0]     out_row_q;
  logic [WRAP_W-1:0] out_wraps_q;
  logic [CHAR_W-1:0] out_cell_q;

  // RAM port controls.
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CHAR_W-1:0] mem_wdata, mem_rdata;

  // Decode flags used by the controller blocks.
  logic cmd_accept;
  logic go_sweep;
  logic go_read;
  logic finish;
  logic out_free;
  logic sweep_at_end;

  logic [AW-1:0] scroll_start;
  logic [RW-1:0] top_next;

  // Physical RAM address of a logical cell under a given ring offset.
  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                              input logic [CW-1:0] col,
                                              input logic [RW-1:0] top);
    logic [RW:0]   sum;
    logic [RW-1:0] prow;
    sum = {1'b0, row} + {1'b0, top};
    if (sum >= ROWS_X) begin
      sum = sum - ROWS_X;
    end
    prow = sum[RW-1:0];
    return (AW'(prow) * COLS_A) + AW'(col);
  endfunction

  assign cmd_accept   = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready  = (state_q == ST_IDLE);
  assign out_free     = !out_valid_q || rsp_o.ready;
  assign sweep_at_end = (sweep_addr_q == sweep_end_q);

  // The row that falls off the top becomes the new bottom row.
  assign scroll_start = AW'(top_q) * COLS_A;
  assign top_next     = (top_q == LAST_ROW) ? '0 : top_q + RW'(1);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (sweep_addr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (go_sweep) begin
          state_d = ST_SWEEP;
        end else if (go_read) begin
          state_d = ST_RDATA;
        end
      end
      default: begin
      end
    endcase
    if (finish) begin
      state_d = out_free ? ST_IDLE : ST_DONE;
    end
  end

  // Datapath and RAM controls. Only one command is in flight, and a write in
  // one command always lands before any later command's read, so no forwarding
  // is needed around the RAM.
  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    top_d        = top_q;
    wraps_d      = wraps_q;
    sweep_addr_d = sweep_addr_q;
    sweep_end_d  = sweep_end_q;
    cell_d       = cell_q;
    mem_we       = 1'b0;
    mem_waddr    = sweep_addr_q;
    mem_wdata    = SPACE_CHAR;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    go_sweep     = 1'b0;
    go_read      = 1'b0;
    finish       = 1'b0;

    case (state_q)
      ST_INIT: begin
        mem_we       = 1'b1;
        sweep_addr_d = sweep_addr_q + AW'(1);
      end
      ST_EXEC: begin
        cell_d = '0;
        case (cmd_q)
          CMD_PUT: begin
            if (char_q inside {LF_CHAR, CR_CHAR}) begin
              col_d = '0;
              if (row_q == LAST_ROW) begin
                go_sweep = 1'b1;
              end else begin
                row_d = row_q + RW'(1);
              end
            end else begin
              mem_we    = 1'b1;
              mem_waddr = cell_addr(row_q, col_q, top_q);
              mem_wdata = char_q;
              if (col_q == LAST_COL) begin
                col_d = '0;
                if (wraps_q != WRAP_MAX) begin
                  wraps_d = wraps_q + WRAP_W'(1);
                end
                if (row_q == LAST_ROW) begin
                  go_sweep = 1'b1;
                end else begin
                  row_d = row_q + RW'(1);
                end
              end else begin
                col_d = col_q + CW'(1);
              end
            end
            if (go_sweep) begin
              top_d        = top_next;
              sweep_addr_d = scroll_start;
              sweep_end_d  = scroll_start + AW'(LAST_COL);
            end
          end
          CMD_BACKSPACE: begin
            if (col_q == '0) begin
              // Step back to the previous row only while the wrap count is
              // nonzero; the wrap count ends unchanged.
              if (wraps_q != '0 && row_q != '0) begin
                row_d     = row_q - RW'(1);
                col_d     = LAST_COL;
                mem_we    = 1'b1;
                mem_waddr = cell_addr(row_q - RW'(1), LAST_COL, top_q);
              end
            end else begin
              col_d     = col_q - CW'(1);
              mem_we    = 1'b1;
              mem_waddr = cell_addr(row_q, col_q - CW'(1), top_q);
            end
          end
          CMD_CLEAR: begin
            col_d        = '0;
            row_d        = '0;
            top_d        = '0;
            go_sweep     = 1'b1;
            sweep_addr_d = '0;
            sweep_end_d  = LAST_ADDR;
          end
          CMD_RESET_WRAP: begin
            wraps_d = '0;
          end
          CMD_READ: begin
            if (32'(rrow_q) < ROWS && 32'(rcol_q) < COLUMNS) begin
              mem_re    = 1'b1;
              mem_raddr = cell_addr(rrow_q[RW-1:0], rcol_q[CW-1:0], top_q);
              go_read   = 1'b1;
            end
          end
          default: begin
          end
        endcase
        finish = !go_sweep && !go_read;
      end
      ST_SWEEP: begin
        mem_we       = 1'b1;
        sweep_addr_d = sweep_addr_q + AW'(1);
        finish       = sweep_at_end;
      end
      ST_RDATA: begin
        cell_d = mem_rdata;
        finish = 1'b1;
      end
      ST_DONE: begin
        finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // The response register takes the finished command's word while the
  // previous word is gone or leaving.
  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (finish && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      col_q        <= '0;
      row_q        <= '0;
      top_q        <= '0;
      wraps_q      <= '0;
      sweep_addr_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      col_q        <= col_d;
      row_q        <= row_d;
      top_q        <= top_d;
      wraps_q      <= wraps_d;
      sweep_addr_q <= sweep_addr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_accept) begin
      cmd_q  <= cmd_i.cmd;
      char_q <= cmd_i.char_code;
      rrow_q <= cmd_i.read_row;
      rcol_q <= cmd_i.read_col;
    end
    sweep_end_q <= sweep_end_d;
    cell_q      <= cell_d;
    if (finish && out_free) begin
      out_col_q   <= col_d;
      out_row_q   <= row_d;
      out_wraps_q <= wraps_d;
      out_cell_q  <= cell_d;
    end
  end

  tcw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.cursor_col = COL_W'(out_col_q);
  assign rsp_o.cursor_row = ROW_W'(out_row_q);
  assign rsp_o.wrap_count = out_wraps_q;
  assign rsp_o.cell_char  = out_cell_q;

`ifndef SYNTHESIS
  // The cursor and the ring offset always address a cell on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= LAST_COL && row_q <= LAST_ROW && top_q <= LAST_ROW)
    else $error("cursor or ring offset left the screen");

  // A read and a write never share a RAM cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("screen RAM read and write in the same cycle");

  // A sweep never runs past its last address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SWEEP |-> sweep_addr_q <= sweep_end_q)
    else $error("sweep ran past its end");

  // An accepted command starts executing in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_accept |=> state_q == ST_EXEC)
    else $error("accepted command did not execute");

  // A response word is produced only when a command finishes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q ##1 out_valid_q |-> $past(finish))
    else $error("response word without a finished command");
`endif

endmodule : text_console_writer

`default_nettype wire

// File: rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : tcw_ram

`default_nettype wire
